>>> rtl/core/sli_pkg.sv
// Package for the status light block: types, timing constants, register map.
// No dependencies; used by the controller, datapath and top level of the block.
package sli_pkg;

    localparam int TIME_W = 32;
    localparam int CNT_W  = $clog2(TIME_W);
    localparam int REM_W  = 13;
    localparam int FLT_W  = 16;
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    localparam logic [TIME_W-1:0] SWEEP_RED_END   = 32'd1000;
    localparam logic [TIME_W-1:0] SWEEP_GREEN_END = 32'd2000;
    localparam logic [TIME_W-1:0] SWEEP_END       = 32'd3000;
    localparam logic [TIME_W-1:0] BLIP_LEN        = 32'd300;

    localparam logic [REM_W-1:0] SLOW_PERIOD = 13'd800;
    localparam logic [REM_W-1:0] SLOW_ON     = 13'd400;
    localparam logic [REM_W-1:0] FAST_PERIOD = 13'd200;
    localparam logic [REM_W-1:0] FAST_ON     = 13'd100;
    localparam logic [REM_W-1:0] CODE_SLOT   = 13'd300;
    localparam logic [REM_W-1:0] CODE_ON     = 13'd150;
    localparam logic [REM_W-1:0] CODE_GAP    = 13'd900;

    localparam logic [2:0] ST_BOOT      = 3'd0;
    localparam logic [2:0] ST_STANDBY   = 3'd1;
    localparam logic [2:0] ST_PUMPING   = 3'd2;
    localparam logic [2:0] ST_READY     = 3'd3;
    localparam logic [2:0] ST_ARMED     = 3'd4;
    localparam logic [2:0] ST_ACTUATING = 3'd5;
    localparam logic [2:0] ST_FAILSAFE  = 3'd6;
    localparam logic [2:0] ST_FAULT     = 3'd7;

    localparam logic [1:0] GEST_DOUBLE = 2'd1;
    localparam logic [1:0] GEST_LONG   = 2'd2;

    localparam logic [FLT_W-1:0] LINK_FAULT_MASK = 16'h0201;

    localparam logic [1:0] REG_ACTIVE_LOW    = 2'd0;
    localparam logic [1:0] REG_ASSEMBLY_TEST = 2'd1;
    localparam logic [1:0] REG_BLIP_ENABLE   = 2'd2;
    localparam logic [1:0] REG_BENCH_CONTROL = 2'd3;

    typedef enum logic [1:0] {
        COL_OFF,
        COL_RED,
        COL_GREEN,
        COL_BLUE
    } color_t;

    typedef enum logic [1:0] {
        BLINK_STEADY,
        BLINK_SLOW,
        BLINK_QUICK
    } blink_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PASS1,
        S_LOAD2,
        S_PASS2,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic active_low;
        logic assembly_test;
        logic blip_enable;
        logic bench_control;
    } cfg_t;

    typedef struct packed {
        logic capture;
        logic step;
        logic pass2;
        logic result;
    } dp_cmd_t;

    typedef struct packed {
        logic step_last;
    } dp_stat_t;

endpackage

>>> rtl/core/sli_ctrl.sv
// Controller for the status light block: sequences capture, two remainder
// passes and the result load. Depends on sli_pkg.
module sli_ctrl
    import sli_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    output logic     out_valid,
    input  logic     out_stall,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        in_stall    = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_PASS1;
                end
            end
            S_PASS1:
            begin
                cmd.step = 1'b1;
                if (stat.step_last)
                    state_next = S_LOAD2;
            end
            S_LOAD2:
            begin
                cmd.pass2  = 1'b1;
                state_next = S_PASS2;
            end
            S_PASS2:
            begin
                cmd.step = 1'b1;
                if (stat.step_last)
                    state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.result = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        out_valid_next = (out_valid_reg && out_stall) || cmd.result;
    end

    assign out_valid = out_valid_reg;

endmodule

>>> rtl/core/sli_dp.sv
// Datapath for the status light block: priority decode, gesture blip state,
// bit-serial remainder unit and output levels. Depends on sli_pkg.
module sli_dp
    import sli_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_t              cfg,
    input  dp_cmd_t           cmd,
    output dp_stat_t          stat,
    input  logic [TIME_W-1:0] time_ms,
    input  logic [2:0]        system_state,
    input  logic [FLT_W-1:0]  fault_bits,
    input  logic              heartbeat_fresh,
    input  logic              host_seen,
    input  logic [1:0]        gesture_code,
    input  logic [7:0]        gesture_seq,
    output logic              red_level,
    output logic              green_level,
    output logic              blue_level
);

    // gesture blip state
    logic [7:0]        last_seq_reg;
    logic              seq_captured_reg;
    logic [1:0]        blip_gesture_reg;
    logic [TIME_W-1:0] blip_end_reg;

    // decoded item
    color_t            col_reg;
    color_t            col_next;
    blink_t            pat_reg;
    blink_t            pat_next;
    logic              code_reg;
    logic              code_next;
    logic [REM_W-1:0]  n300_reg;
    logic [REM_W-1:0]  div2_reg;

    // remainder unit
    logic [TIME_W-1:0] dvd_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [REM_W-1:0]  rem1_reg;
    logic [REM_W-1:0]  divisor_reg;
    logic [CNT_W-1:0]  cnt_reg;

    logic              red_reg;
    logic              green_reg;
    logic              blue_reg;

    logic              sweep;
    logic              code_mode;
    logic              blip_on;
    logic              seen_eff;
    logic [3:0]        low_bit;
    logic [4:0]        n_val;
    logic [REM_W-1:0]  n300;
    logic [7:0]        last_eff;
    logic              new_seq;
    logic [TIME_W-1:0] end_eff;
    logic [1:0]        gest_eff;
    logic [TIME_W-1:0] diff;
    logic              pending;
    logic              blip_upd;

    logic [REM_W:0]    trial;
    logic [REM_W:0]    trial_sub;
    logic              trial_ge;
    logic [REM_W-1:0]  rem_step;

    logic              lit;
    logic              r_on;
    logic              g_on;
    logic              b_on;

    always_comb
    begin
        low_bit = 4'd15;
        for (int b = FLT_W - 1; b >= 0; b--)
        begin
            if (fault_bits[b])
                low_bit = 4'(b);
        end
        n_val = {1'b0, low_bit} + 5'd1;
        n300  = REM_W'(n_val * CODE_SLOT);
    end

    always_comb
    begin
        sweep     = cfg.assembly_test && (time_ms < SWEEP_END);
        code_mode = cfg.assembly_test && !sweep && (system_state == ST_FAULT) &&
                    (fault_bits != '0);
        seen_eff  = host_seen || cfg.assembly_test;
        blip_on   = cfg.blip_enable || cfg.bench_control;
        last_eff  = seq_captured_reg ? last_seq_reg : gesture_seq;
        new_seq   = (gesture_seq != last_eff);
        end_eff   = new_seq ? (time_ms + BLIP_LEN) : blip_end_reg;
        gest_eff  = new_seq ? gesture_code : blip_gesture_reg;
        diff      = end_eff - time_ms;
        pending   = (diff != '0) && !diff[TIME_W-1];
        blip_upd  = cmd.capture && !sweep && !code_mode && blip_on;

        col_next  = COL_BLUE;
        pat_next  = BLINK_QUICK;
        code_next = 1'b0;
        if (sweep)
        begin
            pat_next = BLINK_STEADY;
            if (time_ms < SWEEP_RED_END)
                col_next = COL_RED;
            else if (time_ms < SWEEP_GREEN_END)
                col_next = COL_GREEN;
            else
                col_next = COL_BLUE;
        end
        else if (code_mode)
        begin
            code_next = 1'b1;
        end
        else if (blip_on && pending)
        begin
            if (gest_eff == GEST_LONG)
                col_next = COL_RED;
            else if (gest_eff == GEST_DOUBLE)
                col_next = COL_BLUE;
            else
                col_next = COL_GREEN;
        end
        else if (system_state == ST_FAULT)
        begin
            col_next = COL_RED;
        end
        else if (cfg.bench_control && !seen_eff &&
                 (system_state == ST_BOOT || system_state == ST_STANDBY))
        begin
            col_next = COL_GREEN;
            pat_next = BLINK_SLOW;
        end
        else if (!seen_eff)
        begin
            pat_next = BLINK_STEADY;
        end
        else if (!heartbeat_fresh || ((fault_bits & LINK_FAULT_MASK) != '0))
        begin
            col_next = COL_BLUE;
        end
        else
        begin
            case (system_state)
                ST_ACTUATING:
                begin
                    col_next = COL_RED;
                    pat_next = BLINK_STEADY;
                end
                ST_FAILSAFE:
                begin
                    col_next = COL_RED;
                    pat_next = BLINK_SLOW;
                end
                ST_ARMED:
                begin
                    col_next = COL_GREEN;
                end
                ST_READY:
                begin
                    col_next = COL_GREEN;
                    pat_next = BLINK_SLOW;
                end
                ST_PUMPING:
                begin
                    pat_next = BLINK_SLOW;
                end
                ST_STANDBY:
                begin
                    col_next = COL_GREEN;
                    pat_next = BLINK_STEADY;
                end
                default:
                begin
                    col_next = COL_BLUE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_seq_reg     <= '0;
            seq_captured_reg <= 1'b0;
            blip_gesture_reg <= '0;
            blip_end_reg     <= '0;
        end
        else if (blip_upd)
        begin
            last_seq_reg     <= gesture_seq;
            seq_captured_reg <= 1'b1;
            blip_gesture_reg <= gest_eff;
            blip_end_reg     <= end_eff;
        end
    end

    // one quotient bit per cycle, remainder only
    always_comb
    begin
        trial     = {rem_reg, dvd_reg[TIME_W-1]};
        trial_sub = trial - {1'b0, divisor_reg};
        trial_ge  = (trial >= {1'b0, divisor_reg});
        rem_step  = trial_ge ? trial_sub[REM_W-1:0] : trial[REM_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            col_reg     <= col_next;
            pat_reg     <= pat_next;
            code_reg    <= code_next;
            n300_reg    <= n300;
            dvd_reg     <= time_ms;
            rem_reg     <= '0;
            cnt_reg     <= '0;
            divisor_reg <= code_next ? (n300 + CODE_GAP) : SLOW_PERIOD;
            div2_reg    <= code_next ? CODE_SLOT : FAST_PERIOD;
        end
        else if (cmd.pass2)
        begin
            rem1_reg    <= rem_reg;
            dvd_reg     <= {{(TIME_W-REM_W){1'b0}}, rem_reg};
            rem_reg     <= '0;
            cnt_reg     <= '0;
            divisor_reg <= div2_reg;
        end
        else if (cmd.step)
        begin
            dvd_reg <= {dvd_reg[TIME_W-2:0], 1'b0};
            rem_reg <= rem_step;
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    assign stat.step_last = (cnt_reg == CNT_W'(TIME_W - 1));

    always_comb
    begin
        if (code_reg)
            lit = (rem1_reg < n300_reg) && (rem_reg < CODE_ON);
        else
        begin
            case (pat_reg)
                BLINK_SLOW:  lit = (rem1_reg < SLOW_ON);
                BLINK_QUICK: lit = (rem_reg < FAST_ON);
                default:     lit = 1'b1;
            endcase
        end
        r_on = lit && !code_reg && (col_reg == COL_RED);
        g_on = lit && !code_reg && (col_reg == COL_GREEN);
        b_on = lit && (code_reg || col_reg == COL_BLUE);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.result)
        begin
            red_reg   <= r_on ^ cfg.active_low;
            green_reg <= g_on ^ cfg.active_low;
            blue_reg  <= b_on ^ cfg.active_low;
        end
    end

    assign red_level   = red_reg;
    assign green_level = green_reg;
    assign blue_level  = blue_reg;

endmodule

>>> rtl/core/status_led_indicator.sv
// Status light driver: one update in, one set of pin levels out.
// An accepted update goes through two bit-serial remainder passes, a reload
// step and a result load, all on the shared remainder unit; a new update is
// taken only once the last result has been loaded (in_stall high until then).
// Reset (rst_n, async low) clears config registers, blip state and handshakes.
module status_led_indicator
    import sli_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [TIME_W-1:0] time_ms,
    input  logic [2:0]        system_state,
    input  logic [FLT_W-1:0]  fault_bits,
    input  logic              heartbeat_fresh,
    input  logic              host_seen,
    input  logic [1:0]        gesture_code,
    input  logic [7:0]        gesture_seq,
    output logic              out_valid,
    input  logic              out_stall,
    output logic              red_level,
    output logic              green_level,
    output logic              blue_level
);

    cfg_t     cfg_reg;
    dp_cmd_t  cmd;
    dp_stat_t stat;
    logic     wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else if (wr_en)
        begin
            case (reg_idx)
                REG_ACTIVE_LOW:    cfg_reg.active_low    <= pwdata[0];
                REG_ASSEMBLY_TEST: cfg_reg.assembly_test <= pwdata[0];
                REG_BLIP_ENABLE:   cfg_reg.blip_enable   <= pwdata[0];
                REG_BENCH_CONTROL: cfg_reg.bench_control <= pwdata[0];
                default:           cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        case (reg_idx)
            REG_ACTIVE_LOW:    prdata[0] = cfg_reg.active_low;
            REG_ASSEMBLY_TEST: prdata[0] = cfg_reg.assembly_test;
            REG_BLIP_ENABLE:   prdata[0] = cfg_reg.blip_enable;
            REG_BENCH_CONTROL: prdata[0] = cfg_reg.bench_control;
            default:           prdata = '0;
        endcase
    end

    sli_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    sli_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg_reg),
        .cmd             (cmd),
        .stat            (stat),
        .time_ms         (time_ms),
        .system_state    (system_state),
        .fault_bits      (fault_bits),
        .heartbeat_fresh (heartbeat_fresh),
        .host_seen       (host_seen),
        .gesture_code    (gesture_code),
        .gesture_seq     (gesture_seq),
        .red_level       (red_level),
        .green_level     (green_level),
        .blue_level      (blue_level)
    );

endmodule

>>> rtl/core/sli_checker.sv
// Port-level checks for the status light block, bound to the top level.
// Depends on status_led_indicator ports only.
module sli_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_stall,
    input logic out_valid,
    input logic out_stall,
    input logic red_level,
    input logic green_level,
    input logic blue_level
);

    // a presented result always carries known levels
    a_levels_known: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !$isunknown({red_level, green_level, blue_level}))
        else $error("pin levels unknown on a valid result");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input taken while an item is in progress");

    a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared without an item in progress");

    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid)
        else $error("result dropped while stalled");

    a_levels_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=>
            $stable({red_level, green_level, blue_level}))
        else $error("result changed while stalled");

endmodule

bind status_led_indicator sli_checker u_sli_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .red_level   (red_level),
    .green_level (green_level),
    .blue_level  (blue_level)
);
